// File: hw/rtl/bsdp_pkg.sv
// Shared types and constants for the button single/double press detector.
package bsdp_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned GEST_W   = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = CFG_IDX_W'(1);

  // Register reset values
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(50);
  localparam logic [CFG_W-1:0] WINDOW_RESET   = CFG_W'(400);

  // Result codes
  localparam logic [GEST_W-1:0] GEST_NONE   = GEST_W'(0);
  localparam logic [GEST_W-1:0] GEST_SINGLE = GEST_W'(1);
  localparam logic [GEST_W-1:0] GEST_DOUBLE = GEST_W'(2);

  // Timing settings handed to the classifier
  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] double_window_ms;
  } cfg_t;

  // One registered sample
  typedef struct packed {
    logic              level;
    logic [TIME_W-1:0] now_ms;
  } sample_t;

endpackage

// File: hw/rtl/bsdp_cfg_regs.sv
// Configuration registers: debounce time and double-press window.
module bsdp_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [bsdp_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [bsdp_pkg::CFG_W-1:0]    wr_data,
  output bsdp_pkg::cfg_t                cfg
);
  import bsdp_pkg::*;

  cfg_t regs;

  // Writes to unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.debounce_ms      <= DEBOUNCE_RESET;
      regs.double_window_ms <= WINDOW_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_DEBOUNCE: regs.debounce_ms      <= wr_data;
        REG_WINDOW:   regs.double_window_ms <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

// File: hw/rtl/bsdp_classifier.sv
// Press classifier: phase machine, edge times and the registered result.
module bsdp_classifier (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  bsdp_pkg::sample_t           sample,
  input  bsdp_pkg::cfg_t              cfg,
  output logic [bsdp_pkg::GEST_W-1:0] gesture
);
  import bsdp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE        = 2'd0,
    PH_FIRST_DOWN  = 2'd1,
    PH_WAIT_SECOND = 2'd2,
    PH_SECOND_DOWN = 2'd3
  } phase_t;

  phase_t            phase, phase_next;
  logic [TIME_W-1:0] press_time, press_time_next;
  logic [TIME_W-1:0] release_time, release_time_next;
  logic              previous_level;
  logic [GEST_W-1:0] gesture_next;

  logic              fall, rise;
  logic [TIME_W-1:0] since_press, since_release;
  logic              press_ok, release_ok, window_over;

  // Edge detection and wrapping elapsed times
  assign fall          = !sample.level && previous_level;
  assign rise          = sample.level && !previous_level;
  assign since_press   = sample.now_ms - press_time;
  assign since_release = sample.now_ms - release_time;
  assign press_ok      = since_press > TIME_W'(cfg.debounce_ms);
  assign release_ok    = since_release > TIME_W'(cfg.debounce_ms);
  assign window_over   = since_release > TIME_W'(cfg.double_window_ms);

  // Next phase; a press in the window beats the timeout
  always_comb begin
    phase_next        = phase;
    press_time_next   = press_time;
    release_time_next = release_time;
    gesture_next      = GEST_NONE;
    case (phase)
      PH_IDLE: begin
        if (fall && release_ok) begin
          phase_next      = PH_FIRST_DOWN;
          press_time_next = sample.now_ms;
        end
      end
      PH_FIRST_DOWN: begin
        if (rise && press_ok) begin
          phase_next        = PH_WAIT_SECOND;
          release_time_next = sample.now_ms;
        end
      end
      PH_WAIT_SECOND: begin
        if (fall && release_ok) begin
          phase_next      = PH_SECOND_DOWN;
          press_time_next = sample.now_ms;
        end else if (window_over) begin
          phase_next   = PH_IDLE;
          gesture_next = GEST_SINGLE;
        end
      end
      PH_SECOND_DOWN: begin
        if (rise && press_ok) begin
          phase_next        = PH_IDLE;
          release_time_next = sample.now_ms;
          gesture_next      = GEST_DOUBLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // State and result register, updated as each item leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      press_time     <= '0;
      release_time   <= '0;
      previous_level <= 1'b1;
      gesture        <= GEST_NONE;
    end else if (advance) begin
      phase          <= phase_next;
      press_time     <= press_time_next;
      release_time   <= release_time_next;
      previous_level <= sample.level;
      gesture        <= gesture_next;
    end
  end

endmodule

// File: hw/rtl/button_single_double_press_detector.sv
// Flow: an accepted item is held in the input stage and moves into the result
// register when that register can move, and from there it can be taken.
// Throughput: one item per cycle; the input stage and result register keep the
// stream moving while out_stall is low, and a stalled result holds one item back.
// Reset (rst, synchronous): phase idle, edge times zero, previous level released,
// debounce 50 ms, window 400 ms, both stages empty.
module button_single_double_press_detector (
  input  logic                           clk,
  input  logic                           rst,
  // sample channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           level,
  input  logic [bsdp_pkg::TIME_W-1:0]    now_ms,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bsdp_pkg::GEST_W-1:0]    gesture,
  // configuration channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsdp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsdp_pkg::CFG_W-1:0]     cfg_data
);
  import bsdp_pkg::*;

  cfg_t    cfg;
  sample_t sample;
  logic    sample_valid;
  logic    out_free, advance, take;

  // Handshake: the input stage drains whenever the result register can move
  assign out_free = !out_valid || !out_stall;
  assign advance  = sample_valid && out_free;
  assign in_stall = sample_valid && !out_free;
  assign take     = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (take || advance) begin
      sample_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample.level  <= level;
      sample.now_ms <= now_ms;
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= sample_valid;
    end
  end

  bsdp_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bsdp_classifier u_class (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (sample),
    .cfg     (cfg),
    .gesture (gesture)
  );

endmodule

// File: hw/rtl/bsdp_checker.sv
// Port-level checks for the press detector, bound to the top level.
module bsdp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bsdp_pkg::GEST_W-1:0] gesture
);
  import bsdp_pkg::*;

  // Never an undefined result code
  a_gesture_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gesture == GEST_NONE || gesture == GEST_SINGLE ||
                   gesture == GEST_DOUBLE))
    else $error("gesture carries an undefined code");

  // Input pushes back only when a result is pending and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register could move");

  // Stalled result is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(gesture)))
    else $error("stalled result changed or vanished");

  // Reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind button_single_double_press_detector bsdp_checker u_bsdp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .gesture   (gesture)
);
